>>> rtl/core/dsdl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted draw list package
// Shared constants and types for the cell chain that holds the sorted list.
// ----------------------------------------------------------------------------
package dsdl_pkg;

	localparam int unsigned ListCapacity = 64;
	localparam int unsigned CountW = $clog2(ListCapacity + 1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DRAIN  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef struct packed {
		logic [4:0]  point_count;
		logic [7:0]  colour;
		logic [63:0] coords_a;
		logic [63:0] coords_b;
		logic [63:0] coords_c;
		logic [63:0] coords_d;
	} prim_t;

	typedef struct packed {
		logic [31:0] key;
		prim_t       prim;
	} entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic   insert;
		logic   shift;
		entry_t entry;
	} cell_ctrl_t;

	function automatic logic [31:0] depth_key(input logic signed [31:0] d);
		depth_key = d ^ 32'h8000_0000;
	endfunction

endpackage

>>> rtl/core/dsdl_word_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word channel interface
// Valid/ready channels carrying one payload word each: commands in, primitives out.
// ----------------------------------------------------------------------------
interface dsdl_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] depth;
	logic [4:0]         point_count;
	logic [7:0]         colour;
	logic [63:0]        coords_a;
	logic [63:0]        coords_b;
	logic [63:0]        coords_c;
	logic [63:0]        coords_d;
	modport source (output valid, op, depth, point_count, colour,
		coords_a, coords_b, coords_c, coords_d, input ready);
	modport sink (input valid, op, depth, point_count, colour,
		coords_a, coords_b, coords_c, coords_d, output ready);
endinterface

interface dsdl_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_point_count;
	logic [7:0]  out_colour;
	logic [63:0] out_coords_a;
	logic [63:0] out_coords_b;
	logic [63:0] out_coords_c;
	logic [63:0] out_coords_d;
	logic        last;
	modport source (output valid, out_point_count, out_colour, out_coords_a,
		out_coords_b, out_coords_c, out_coords_d, last, input ready);
	modport sink (input valid, out_point_count, out_colour, out_coords_a,
		out_coords_b, out_coords_c, out_coords_d, last, output ready);
endinterface

>>> rtl/core/dsdl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw list cell
// Holds one entry of the sorted list. On insert a cell keeps its entry, takes
// the new one, or takes its upstream neighbor's; on drain the chain rotates
// toward cell 0, each cell taking its downstream neighbor's entry.
// ----------------------------------------------------------------------------
module dsdl_cell import dsdl_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       prev_goes_after,
	input  entry_t     prev_entry,
	input  entry_t     next_entry,
	input  logic       occupied,
	output logic       goes_after,
	output entry_t     entry
);
	entry_t entry_q;
	logic   after_me;

	assign entry = entry_q;
	// new word lands behind every occupied entry with key >= its own
	assign after_me = occupied && (entry_q.key >= ctrl.entry.key);
	assign goes_after = after_me;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			entry_q <= next_entry;
		end else if (ctrl.insert && !after_me) begin
			entry_q <= prev_goes_after ? ctrl.entry : prev_entry;
		end
	end
endmodule

>>> rtl/core/depth_sorted_draw_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted draw list, top level
// Insert: all cells compare in parallel and shift in one step. Drain of n
// entries: the drain flag is registered, then n words pass through the output
// register at one per cycle while the sink is ready, set by the chain rotating
// one cell per word; input waits until the last is taken.
// Reset: asynchronous, empties the list; entry payload is not reset.
// ----------------------------------------------------------------------------
module depth_sorted_draw_list_top import dsdl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	dsdl_in_if.sink   in_ch,
	dsdl_out_if.source out_ch
);
	logic [CountW-1:0] count_q;
	logic [CountW-1:0] emit_q;
	logic              drain_q;
	logic              out_valid_q;
	logic              out_last_q;
	prim_t             out_prim_q;

	cell_ctrl_t ctrl;
	entry_t     cell_entry [ListCapacity];
	logic       cell_after [ListCapacity];
	entry_t     new_entry;
	logic       accept;
	logic       emit;

	assign in_ch.ready = !drain_q && !out_valid_q;
	assign accept = in_ch.valid && in_ch.ready;
	assign new_entry.key = depth_key(in_ch.depth);
	assign new_entry.prim = '{in_ch.point_count, in_ch.colour, in_ch.coords_a,
		in_ch.coords_b, in_ch.coords_c, in_ch.coords_d};
	// hand the next word to the output register when it is free or taken
	assign emit = drain_q && (!out_valid_q || out_ch.ready);

	assign ctrl.insert = accept && (op_t'(in_ch.op) == OP_INSERT)
		&& (count_q < CountW'(ListCapacity));
	assign ctrl.shift = emit;
	assign ctrl.entry = new_entry;

	// rotate toward cell 0: the last occupied cell takes cell 0, so the list is
	// intact after the drain
	for (genvar i = 0; i < ListCapacity; i++) begin : g_cell
		dsdl_cell u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.prev_goes_after(i == 0 ? 1'b1 : cell_after[i == 0 ? 0 : i-1]),
			.prev_entry(i == 0 ? new_entry : cell_entry[i == 0 ? 0 : i-1]),
			.next_entry((CountW'(i) == count_q - 1'b1) ? cell_entry[0]
				: cell_entry[i == ListCapacity - 1 ? 0 : i+1]),
			.occupied(CountW'(i) < count_q),
			.goes_after(cell_after[i]),
			.entry(cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emit_q <= '0;
			drain_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (accept) begin
				unique case (op_t'(in_ch.op))
					OP_CLEAR:  count_q <= '0;
					OP_INSERT: if (ctrl.insert) count_q <= count_q + 1'b1;
					OP_DRAIN: begin
						emit_q <= count_q;
						drain_q <= (count_q != '0);
					end
					OP_NONE: ;
				endcase
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_last_q <= (emit_q == CountW'(1));
				emit_q <= emit_q - 1'b1;
				if (emit_q == CountW'(1)) drain_q <= 1'b0;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the entry at the front of the list sits at cell 0 on every emit
	always_ff @(posedge clk) begin
		if (emit) out_prim_q <= cell_entry[0].prim;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.out_point_count = out_prim_q.point_count;
	assign out_ch.out_colour = out_prim_q.colour;
	assign out_ch.out_coords_a = out_prim_q.coords_a;
	assign out_ch.out_coords_b = out_prim_q.coords_b;
	assign out_ch.out_coords_c = out_prim_q.coords_c;
	assign out_ch.out_coords_d = out_prim_q.coords_d;
	assign out_ch.last = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(ListCapacity)) else $error("count overflow");
	a_no_accept_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !in_ch.ready) else $error("input taken during drain");
	a_drain_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drain_q) |-> out_valid_q && out_last_q) else $error("drain end without last");
endmodule

>>> dv/depth_sorted_draw_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-sorted draw list testbench
// Sends clear, insert, drain and unused-op words over a valid/ready channel,
// keeps its own depth-ordered list, and checks every drained word in order.
// Both sides idle at random in the first two of three phases, not in the last.
// ----------------------------------------------------------------------------
module testbench;
	import dsdl_pkg::*;

	typedef struct {
		op_t         op;
		logic [31:0] depth;
		logic [4:0]  point_count;
		logic [7:0]  colour;
		logic [63:0] ca, cb, cc, cd;
	} cmd_t;

	typedef struct {
		logic [4:0]  point_count;
		logic [7:0]  colour;
		logic [63:0] ca, cb, cc, cd;
		logic        last;
	} prim_word_t;

	typedef struct {
		logic signed [31:0] depth;
		prim_word_t         w;
	} slot_t;

	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	dsdl_in_if  in_ch ();
	dsdl_out_if out_ch ();

	depth_sorted_draw_list_top DUT (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cmd_t       pending_cmds[$];
	prim_word_t expected_words[$];
	slot_t      sorted_list[$];
	int         mismatch_count = 0;
	int         words_checked = 0;
	int         drains_sent = 0;
	int         send_idle_pct = 11;
	int         recv_idle_pct = 79;
	int         quiet_cycles = 0;

	// painter's order: new entry goes after all entries with depth >= its own
	task automatic predict_list(input cmd_t c);
		int pos;
		slot_t s;
		prim_word_t w;
		case (c.op)
			OP_CLEAR: sorted_list.delete();
			OP_INSERT: begin
				if (sorted_list.size() < ListCapacity) begin
					s.depth = c.depth;
					s.w = '{c.point_count, c.colour, c.ca, c.cb, c.cc, c.cd, 1'b0};
					pos = 0;
					while (pos < sorted_list.size() && sorted_list[pos].depth >= s.depth)
						pos++;
					sorted_list.insert(pos, s);
				end
			end
			OP_DRAIN: begin
				for (int i = 0; i < sorted_list.size(); i++) begin
					w = sorted_list[i].w;
					w.last = (i == sorted_list.size() - 1);
					expected_words.push_back(w);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	function automatic cmd_t make_cmd(input op_t op, input logic [31:0] d);
		cmd_t c;
		c.op = op;
		c.depth = d;
		c.point_count = 5'($urandom_range(0, 16));
		c.colour = 8'($urandom);
		c.ca = {$urandom, $urandom};
		c.cb = {$urandom, $urandom};
		c.cc = {$urandom, $urandom};
		c.cd = {$urandom, $urandom};
		return c;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		cmd_t c;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (in_ch.valid)
					predict_list(pending_cmds.pop_front());
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					c = pending_cmds[0];
					in_ch.valid <= 1'b1;
					in_ch.op <= c.op;
					in_ch.depth <= c.depth;
					in_ch.point_count <= c.point_count;
					in_ch.colour <= c.colour;
					in_ch.coords_a <= c.ca;
					in_ch.coords_b <= c.cb;
					in_ch.coords_c <= c.cc;
					in_ch.coords_d <= c.cd;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		prim_word_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", 64'(out_ch.out_colour), 64'd0);
				end else begin
					e = expected_words.pop_front();
					words_checked++;
					if (out_ch.out_point_count !== e.point_count)
						report_mismatch("point_count", 64'(out_ch.out_point_count),
							64'(e.point_count));
					if (out_ch.out_colour !== e.colour)
						report_mismatch("colour", 64'(out_ch.out_colour), 64'(e.colour));
					if (out_ch.out_coords_a !== e.ca)
						report_mismatch("coords_a", out_ch.out_coords_a, e.ca);
					if (out_ch.out_coords_b !== e.cb)
						report_mismatch("coords_b", out_ch.out_coords_b, e.cb);
					if (out_ch.out_coords_c !== e.cc)
						report_mismatch("coords_c", out_ch.out_coords_c, e.cc);
					if (out_ch.out_coords_d !== e.cd)
						report_mismatch("coords_d", out_ch.out_coords_d, e.cd);
					if (out_ch.last !== e.last)
						report_mismatch("last", 64'(out_ch.last), 64'(e.last));
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (pending_cmds.size() == 0 && !in_ch.valid && expected_words.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("timeout with %0d words outstanding", expected_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic add_cmd(input cmd_t c);
		pending_cmds.push_back(c);
		if (c.op == OP_DRAIN)
			drains_sent++;
	endtask

	task automatic wait_drained;
		while (pending_cmds.size() > 0 || in_ch.valid || expected_words.size() > 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_depth;
		case ($urandom_range(3))
			0: return $urandom_range(0, 7) - 4;
			1: return {1'b1, 31'($urandom)};
			2: return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int n;
		in_ch.valid = 1'b0;
		in_ch.op = OP_NONE;
		in_ch.depth = '0;
		in_ch.point_count = '0;
		in_ch.colour = '0;
		in_ch.coords_a = '0;
		in_ch.coords_b = '0;
		in_ch.coords_c = '0;
		in_ch.coords_d = '0;
		out_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// directed: empty drain, extremes, ties, unused op, clear
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_INSERT, 32'h8000_0000));
		add_cmd(make_cmd(OP_INSERT, 32'h7fff_ffff));
		add_cmd(make_cmd(OP_INSERT, 32'd5));
		add_cmd(make_cmd(OP_INSERT, 32'd5));
		add_cmd(make_cmd(OP_INSERT, 32'hffff_ffff));
		add_cmd(make_cmd(OP_INSERT, 32'h7fff_ffff));
		add_cmd(make_cmd(OP_NONE, 32'd1));
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_CLEAR, 0));
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_INSERT, 32'd0));
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_CLEAR, 0));
		// fill past capacity so the overflow inserts are dropped
		for (int i = 0; i < ListCapacity + 2; i++)
			add_cmd(make_cmd(OP_INSERT, pick_depth()));
		add_cmd(make_cmd(OP_DRAIN, 0));
		add_cmd(make_cmd(OP_CLEAR, 0));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 79 : 0;
			recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 11 : 0;
			n = 0;
			while (n < 120) begin
				case ($urandom_range(19))
					0: add_cmd(make_cmd(OP_CLEAR, 0));
					1, 2: add_cmd(make_cmd(OP_DRAIN, 0));
					3: add_cmd(make_cmd(OP_NONE, $urandom));
					default: add_cmd(make_cmd(OP_INSERT, pick_depth()));
				endcase
				n++;
			end
			add_cmd(make_cmd(OP_DRAIN, 0));
			wait_drained();
		end
		repeat (100) @(posedge clk);
		$display("sent %0d drains, checked %0d drained words", drains_sent, words_checked);
		$display("%0d mismatches, %0d words left unmatched", mismatch_count,
			expected_words.size());
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
